>>> rtl/gps_time_sentence_parser_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the time-sentence parser checker.
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef GPS_TIME_SENTENCE_PARSER_MACROS_SVH
`define GPS_TIME_SENTENCE_PARSER_MACROS_SVH

// The antecedent holding in a cycle implies the consequent in the same cycle.
`define GTSP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holding in a cycle implies the consequent in the next cycle.
`define GTSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gtsp_pkg.sv
// ---------------------------------------------------------------------------
// gtsp_pkg
// Shared constants, types and template functions of the time-sentence parser.
// ---------------------------------------------------------------------------
package gtsp_pkg;

  // Frame geometry.
  localparam int FrameLen = 37;
  localparam int SumPos   = 34;
  localparam int MsScale  = 1000;

  // Framing and digit characters.
  localparam logic [7:0] CharStart = 8'h3E;  // '>'
  localparam logic [7:0] CharEnd   = 8'h3C;  // '<'
  localparam logic [7:0] CharNone  = 8'h00;  // no fixed character here

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NOT_RECOGNISED = 2'd1,
    ST_BAD_FORMAT     = 2'd2,
    ST_BAD_CHECKSUM   = 2'd3
  } status_t;

  // Numeric field that a frame position feeds.
  typedef enum logic [3:0] {
    FLD_DAY,
    FLD_MONTH,
    FLD_YEAR,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND,
    FLD_MSEC,
    FLD_FIX,
    FLD_NONE
  } field_t;

  // One result item.
  typedef struct packed {
    status_t      status;
    logic [6:0]   day;
    logic [6:0]   month;
    logic [13:0]  year;
    logic [6:0]   hour;
    logic [6:0]   minute;
    logic [6:0]   second;
    logic [19:0]  microsecond;
    logic [3:0]   fix_mode;
  } result_t;

  // Fixed character expected at a position, CharNone for a wildcard.
  function automatic logic [7:0] fixed_char(input logic [5:0] p);
    logic [7:0] c;
    begin
      case (p)
        6'd0:    c = CharStart;
        6'd1:    c = 8'h52;  // 'R'
        6'd2:    c = 8'h54;  // 'T'
        6'd3:    c = 8'h4D;  // 'M'
        6'd26:   c = 8'h31;  // '1'
        6'd32:   c = 8'h3B;  // ';'
        6'd33:   c = 8'h2A;  // '*'
        6'd36:   c = CharEnd;
        default: c = CharNone;
      endcase
      return c;
    end
  endfunction

  // Numeric field fed by a position.
  function automatic field_t field_at(input logic [5:0] p);
    field_t f;
    begin
      case (p)
        6'd4, 6'd5:                f = FLD_HOUR;
        6'd6, 6'd7:                f = FLD_MINUTE;
        6'd8, 6'd9:                f = FLD_SECOND;
        6'd10, 6'd11, 6'd12:       f = FLD_MSEC;
        6'd13, 6'd14:              f = FLD_DAY;
        6'd15, 6'd16:              f = FLD_MONTH;
        6'd17, 6'd18, 6'd19, 6'd20: f = FLD_YEAR;
        6'd23:                     f = FLD_FIX;
        default:                   f = FLD_NONE;
      endcase
      return f;
    end
  endfunction

  // Hex digit value; bit 4 is set when the character is a valid hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    begin
      if (c inside {[8'h30:8'h39]}) begin
        v = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
        v = {1'b1, c[3:0] + 4'd9};
      end else begin
        v = 5'd0;
      end
      return v;
    end
  endfunction

endpackage

>>> rtl/gtsp_in_reg.sv
// ---------------------------------------------------------------------------
// gtsp_in_reg
// Input register: holds one received character until the frame logic takes it.
// ---------------------------------------------------------------------------
module gtsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_char,
  input  logic       advance,
  output logic       char_valid,
  output logic [7:0] char_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;

  // A new item may enter when the slot is empty or is being emptied.
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The character itself needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_rx_char;
    end
  end

  assign char_valid = valid_r;
  assign char_data  = char_r;

endmodule

>>> rtl/gtsp_frame.sv
// ---------------------------------------------------------------------------
// gtsp_frame
// Frame state and per-character checks; builds the result when a frame closes.
// ---------------------------------------------------------------------------
module gtsp_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_char,
  output logic                close,
  output gtsp_pkg::result_t   result
);

  // Frame state.
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        tmpl_err_r, tmpl_err_nxt;
  logic        digit_err_r, digit_err_nxt;
  logic        hex_err_r, hex_err_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic [9:0]  msec_r, msec_nxt;
  logic [3:0]  fix_r, fix_nxt;

  // Working values for the character being stored.
  logic             is_start, full;
  logic [5:0]       p;
  logic [7:0]       fc;
  logic [4:0]       hv;
  gtsp_pkg::field_t fld;
  logic             is_digit;
  logic [3:0]       dig;
  logic [5:0]       s_pos;
  logic [7:0]       s_xor, s_sum;
  logic             s_tmpl, s_digit, s_hex;
  logic [6:0]       s_day, s_month, s_hour, s_minute, s_second;
  logic [13:0]      s_year;
  logic [9:0]       s_msec;
  logic [3:0]       s_fix;
  logic [5:0]       e_pos;
  logic [7:0]       e_xor, e_sum;
  logic             e_tmpl, e_digit, e_hex;
  gtsp_pkg::status_t status;

  always_comb begin
    is_start = (rx_char == gtsp_pkg::CharStart);
    full     = (pos_r >= 6'(gtsp_pkg::FrameLen));
    close    = !is_start && (full || rx_char == gtsp_pkg::CharEnd);

    // A start character stores into a freshly cleared frame at position 0.
    p        = is_start ? 6'd0 : pos_r;
    s_xor    = is_start ? 8'd0 : xor_r;
    s_sum    = is_start ? 8'd0 : sum_r;
    s_tmpl   = is_start ? 1'b0 : tmpl_err_r;
    s_digit  = is_start ? 1'b0 : digit_err_r;
    s_hex    = is_start ? 1'b0 : hex_err_r;
    s_day    = is_start ? 7'd0 : day_r;
    s_month  = is_start ? 7'd0 : month_r;
    s_year   = is_start ? 14'd0 : year_r;
    s_hour   = is_start ? 7'd0 : hour_r;
    s_minute = is_start ? 7'd0 : minute_r;
    s_second = is_start ? 7'd0 : second_r;
    s_msec   = is_start ? 10'd0 : msec_r;
    s_fix    = is_start ? 4'd0 : fix_r;
    s_pos    = p + 6'd1;

    // Fixed-character check against the template.
    fc = gtsp_pkg::fixed_char(p);
    if (fc != gtsp_pkg::CharNone && rx_char != fc) begin
      s_tmpl = 1'b1;
    end

    // Running checksum over the bytes ahead of the checksum digits.
    if (p < 6'(gtsp_pkg::SumPos)) begin
      s_xor = s_xor ^ rx_char;
    end

    // Received checksum, two hex digits.
    hv = gtsp_pkg::hex_value(rx_char);
    if (p == 6'(gtsp_pkg::SumPos) || p == 6'(gtsp_pkg::SumPos + 1)) begin
      if (!hv[4]) begin
        s_hex = 1'b1;
      end else begin
        s_sum = {s_sum[3:0], hv[3:0]};
      end
    end

    // Decimal fields accumulate one digit at a time.
    fld      = gtsp_pkg::field_at(p);
    is_digit = (rx_char inside {[8'h30:8'h39]});
    dig      = rx_char[3:0];
    if (fld != gtsp_pkg::FLD_NONE) begin
      if (!is_digit) begin
        s_digit = 1'b1;
      end else begin
        case (fld)
          gtsp_pkg::FLD_DAY:    s_day    = 7'(s_day * 7'd10 + 7'(dig));
          gtsp_pkg::FLD_MONTH:  s_month  = 7'(s_month * 7'd10 + 7'(dig));
          gtsp_pkg::FLD_YEAR:   s_year   = 14'(s_year * 14'd10 + 14'(dig));
          gtsp_pkg::FLD_HOUR:   s_hour   = 7'(s_hour * 7'd10 + 7'(dig));
          gtsp_pkg::FLD_MINUTE: s_minute = 7'(s_minute * 7'd10 + 7'(dig));
          gtsp_pkg::FLD_SECOND: s_second = 7'(s_second * 7'd10 + 7'(dig));
          gtsp_pkg::FLD_MSEC:   s_msec   = 10'(s_msec * 10'd10 + 10'(dig));
          gtsp_pkg::FLD_FIX:    s_fix    = dig;
          default: ;
        endcase
      end
    end

    // Next state: a close clears everything, otherwise the stored values.
    if (close) begin
      pos_nxt       = 6'd0;
      xor_nxt       = 8'd0;
      sum_nxt       = 8'd0;
      tmpl_err_nxt  = 1'b0;
      digit_err_nxt = 1'b0;
      hex_err_nxt   = 1'b0;
      day_nxt       = 7'd0;
      month_nxt     = 7'd0;
      year_nxt      = 14'd0;
      hour_nxt      = 7'd0;
      minute_nxt    = 7'd0;
      second_nxt    = 7'd0;
      msec_nxt      = 10'd0;
      fix_nxt       = 4'd0;
    end else begin
      pos_nxt       = s_pos;
      xor_nxt       = s_xor;
      sum_nxt       = s_sum;
      tmpl_err_nxt  = s_tmpl;
      digit_err_nxt = s_digit;
      hex_err_nxt   = s_hex;
      day_nxt       = s_day;
      month_nxt     = s_month;
      year_nxt      = s_year;
      hour_nxt      = s_hour;
      minute_nxt    = s_minute;
      second_nxt    = s_second;
      msec_nxt      = s_msec;
      fix_nxt       = s_fix;
    end

    // A full frame drops the character; an end character is stored first.
    e_pos   = full ? pos_r : s_pos;
    e_xor   = full ? xor_r : s_xor;
    e_sum   = full ? sum_r : s_sum;
    e_tmpl  = full ? tmpl_err_r : s_tmpl;
    e_digit = full ? digit_err_r : s_digit;
    e_hex   = full ? hex_err_r : s_hex;

    if (e_tmpl || e_pos != 6'(gtsp_pkg::FrameLen)) begin
      status = gtsp_pkg::ST_NOT_RECOGNISED;
    end else if (e_digit) begin
      status = gtsp_pkg::ST_BAD_FORMAT;
    end else if (e_hex || e_sum != e_xor) begin
      status = gtsp_pkg::ST_BAD_CHECKSUM;
    end else begin
      status = gtsp_pkg::ST_OK;
    end

    // A closing character feeds no field, so the fields are the stored ones.
    result        = '0;
    result.status = status;
    if (status == gtsp_pkg::ST_OK) begin
      result.day         = day_r;
      result.month       = month_r;
      result.year        = year_r;
      result.hour        = hour_r;
      result.minute      = minute_r;
      result.second      = second_r;
      result.microsecond = 20'(msec_r) * 20'(gtsp_pkg::MsScale);
      result.fix_mode    = fix_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 6'd0;
      xor_r       <= 8'd0;
      sum_r       <= 8'd0;
      tmpl_err_r  <= 1'b0;
      digit_err_r <= 1'b0;
      hex_err_r   <= 1'b0;
      day_r       <= 7'd0;
      month_r     <= 7'd0;
      year_r      <= 14'd0;
      hour_r      <= 7'd0;
      minute_r    <= 7'd0;
      second_r    <= 7'd0;
      msec_r      <= 10'd0;
      fix_r       <= 4'd0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      sum_r       <= sum_nxt;
      tmpl_err_r  <= tmpl_err_nxt;
      digit_err_r <= digit_err_nxt;
      hex_err_r   <= hex_err_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      msec_r      <= msec_nxt;
      fix_r       <= fix_nxt;
    end
  end

endmodule

>>> rtl/gtsp_out_reg.sv
// ---------------------------------------------------------------------------
// gtsp_out_reg
// Result register: holds one finished result until the receiver takes it.
// ---------------------------------------------------------------------------
module gtsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  gtsp_pkg::result_t result_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              space,
  output gtsp_pkg::result_t result_out
);

  logic              valid_r, valid_nxt;
  gtsp_pkg::result_t result_r;

  // Room for a new result when empty or when the current one leaves now.
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule

>>> rtl/gps_time_sentence_parser.sv
// ---------------------------------------------------------------------------
// gps_time_sentence_parser
// Parses a fixed 37-character time sentence, one character per item.
// ---------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_rx_char) takes one received
// character per item. A '>' starts a frame; a '<', or any other character
// arriving when 37 characters are held, closes it and yields one result on
// the output channel (out_valid, out_ready, out_*): status plus date, time,
// microseconds and fix digit, all zero unless status is ok.
// An accepted character is held in the input register; the frame logic then
// updates its state from it and, on a close, loads the result register, which
// offers the result on the output channel.
// One character is taken per cycle while no closing character is held back;
// the frame state update and the result register load happen in the same cycle.
// While the receiver stalls, characters that do not close a frame keep
// flowing; a closing character waits in the input register until the result
// register has room, and meanwhile in_ready stays low.
// Synchronous reset empties both registers and clears the frame state, so
// the parser waits for a new start character.
// ---------------------------------------------------------------------------
module gps_time_sentence_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_day,
  output logic [6:0]  out_month,
  output logic [13:0] out_year,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  output logic [19:0] out_microsecond,
  output logic [3:0]  out_fix_mode
);

  logic              char_valid;
  logic [7:0]        char_data;
  logic              advance;
  logic              close;
  logic              space;
  gtsp_pkg::result_t frame_result;
  gtsp_pkg::result_t out_result;

  // Input register.
  gtsp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_char (in_rx_char),
    .advance    (advance),
    .char_valid (char_valid),
    .char_data  (char_data)
  );

  // A held character moves on unless it closes a frame and the result is blocked.
  assign advance = char_valid && (!close || space);

  // Frame logic.
  gtsp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_char (char_data),
    .close   (close),
    .result  (frame_result)
  );

  // Result register.
  gtsp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && close),
    .result_in  (frame_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .space      (space),
    .result_out (out_result)
  );

  assign out_status      = out_result.status;
  assign out_day         = out_result.day;
  assign out_month       = out_result.month;
  assign out_year        = out_result.year;
  assign out_hour        = out_result.hour;
  assign out_minute      = out_result.minute;
  assign out_second      = out_result.second;
  assign out_microsecond = out_result.microsecond;
  assign out_fix_mode    = out_result.fix_mode;

endmodule

>>> rtl/gtsp_checker.sv
// ---------------------------------------------------------------------------
// gtsp_checker
// Port-level checks of the time-sentence parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "gps_time_sentence_parser_macros.svh"

module gtsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_char,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [6:0]  out_day,
  input logic [6:0]  out_month,
  input logic [13:0] out_year,
  input logic [6:0]  out_hour,
  input logic [6:0]  out_minute,
  input logic [6:0]  out_second,
  input logic [19:0] out_microsecond,
  input logic [3:0]  out_fix_mode
);

  // A stalled result stays offered, with its status, day, year and microseconds unchanged.
  `GTSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_year) && $stable(out_microsecond) && $stable(out_day), "stalled result changed")

  // A failed frame reports all fields as zero.
  `GTSP_ASSERT_IMPLY(a_fail_zero, out_valid && out_status != gtsp_pkg::ST_OK, out_day == 7'd0 && out_month == 7'd0 && out_year == 14'd0 && out_hour == 7'd0 && out_minute == 7'd0 && out_second == 7'd0 && out_microsecond == 20'd0 && out_fix_mode == 4'd0, "failed frame carries field data")

  // A good frame carries decimal-range fields only.
  `GTSP_ASSERT_IMPLY(a_ok_range, out_valid && out_status == gtsp_pkg::ST_OK, out_day <= 7'd99 && out_month <= 7'd99 && out_year <= 14'd9999 && out_hour <= 7'd99 && out_minute <= 7'd99 && out_second <= 7'd99 && out_microsecond <= 20'd999000 && out_fix_mode <= 4'd9, "good frame field out of range")

  // A start character never closes a frame, so it cannot be refused while the
  // result side has room.
  `GTSP_ASSERT_NEXT(a_start_flows, in_valid && in_ready && in_rx_char == gtsp_pkg::CharStart && !out_valid, in_ready, "start character blocked the input")

endmodule

bind gps_time_sentence_parser gtsp_checker u_gtsp_checker (.*);
